/* src/cdha_pkg.sv */
// ----------------------------------------------------------------------------
// cdha_pkg
// Shared types and constants for the color/depth histogram with argmax scan.
// ----------------------------------------------------------------------------
package cdha_pkg;

  // stream word widths
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 32;
  localparam int CFG_W     = 5;

  localparam logic [CFG_W-1:0] COLOR_LIMIT_RESET = 5'd16;

  typedef enum logic [1:0] {
    REQ_OPEN  = 2'd0,
    REQ_INC   = 2'd1,
    REQ_DEC   = 2'd2,
    REQ_QUERY = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_UNDERFLOW = 2'd1,
    STAT_RANGE     = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MODIFY,
    S_CLEAR,
    S_SCAN,
    S_DRAIN,
    S_RESULT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // latch request word, preset result
    logic rd_upd;    // read counter addressed by the input word
    logic wr_upd;    // write back incremented / decremented counter
    logic clr_wr;    // write zero at the clear column, advance
    logic open_inc;  // count one more open row
    logic scan_rd;   // read at scan position, advance
    logic out_load;  // move result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_t in_req;    // request type on the input word
    logic range_ok;  // input row and color are open / in use
    logic full;      // no row left to open
    logic empty;     // nothing to scan
    logic clr_last;  // clear is at its last column
    logic scan_last; // scan is at its last entry
    logic out_free;  // output register can take a word
  } sts_t;

endpackage

/* src/cdha_ram.sv */
// ----------------------------------------------------------------------------
// cdha_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cdha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/cdha_ctrl.sv */
// ----------------------------------------------------------------------------
// cdha_ctrl
// Request sequencer: input handshake, update, row clear and scan steps.
// ----------------------------------------------------------------------------
module cdha_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  cdha_pkg::sts_t  sts,
  output cdha_pkg::cmd_t  cmd
);
  import cdha_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          case (sts.in_req)
            REQ_OPEN:  state_next = sts.full ? S_RESULT : S_CLEAR;
            REQ_INC,
            REQ_DEC:   state_next = sts.range_ok ? S_MODIFY : S_RESULT;
            REQ_QUERY: state_next = sts.empty ? S_RESULT : S_SCAN;
            default:   state_next = S_RESULT;
          endcase
        end
      end
      S_MODIFY: state_next = S_RESULT;
      S_CLEAR: begin
        if (sts.clr_last) begin
          state_next = S_RESULT;
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_RESULT;
      S_RESULT: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        cmd.rd_upd = s_tvalid && sts.range_ok &&
                     (sts.in_req == REQ_INC || sts.in_req == REQ_DEC);
      end
      S_MODIFY: cmd.wr_upd = 1'b1;
      S_CLEAR: begin
        cmd.clr_wr   = 1'b1;
        cmd.open_inc = sts.clr_last;
      end
      S_SCAN:   cmd.scan_rd = 1'b1;
      S_DRAIN:  cmd = '0;
      S_RESULT: cmd.out_load = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

/* src/cdha_dp.sv */
// ----------------------------------------------------------------------------
// cdha_dp
// Counter table, request registers, scan and clear counters, result and
// output registers.
// ----------------------------------------------------------------------------
module cdha_dp #(
  parameter int MAX_COLORS = 16,
  parameter int MAX_DEPTH  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [cdha_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic                             cfg_we,
  input  logic [cdha_pkg::CFG_W-1:0]       cfg_wdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [cdha_pkg::M_TDATA_W-1:0]   m_tdata,
  input  cdha_pkg::cmd_t                   cmd,
  output cdha_pkg::sts_t                   sts
);
  import cdha_pkg::*;

  localparam int CW        = $clog2(MAX_COLORS);
  localparam int DW        = $clog2(MAX_DEPTH);
  localparam int NCW       = $clog2(MAX_COLORS + 1);
  localparam int RW        = $clog2(MAX_DEPTH + 1);
  localparam int RAM_DEPTH = MAX_DEPTH * (1 << CW);
  localparam int AW        = $clog2(RAM_DEPTH);

  // input word fields
  req_t       in_req;
  logic [3:0] in_color;
  logic [3:0] in_depth;
  logic [AW-1:0] in_addr;

  logic [CFG_W-1:0] color_limit;
  logic [NCW-1:0]   ncol;
  logic [RW-1:0]    rows_open;

  req_t          req_q;
  logic [AW-1:0] addr_q;
  logic [CW-1:0] clr_col;
  logic [CW-1:0] scan_c;
  logic [DW-1:0] scan_d;
  logic [CW-1:0] pipe_c;
  logic [DW-1:0] pipe_d;
  logic          pipe_v;
  logic          c_last;
  logic          d_last;

  logic [COUNT_BITS-1:0] res_best;
  logic [CW-1:0]         res_c;
  logic [DW-1:0]         res_d;
  logic                  res_found;
  stat_t                 res_status;
  logic                  bad_req;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] upd_val;

  assign in_req   = req_t'(s_tdata[1:0]);
  assign in_color = s_tdata[5:2];
  assign in_depth = s_tdata[9:6];
  assign in_addr  = {DW'(in_depth), CW'(in_color)};

  assign ncol = (32'(color_limit) > MAX_COLORS) ? NCW'(MAX_COLORS) : NCW'(color_limit);

  assign sts.in_req    = in_req;
  assign sts.range_ok  = (32'(in_color) < 32'(ncol)) && (32'(in_depth) < 32'(rows_open));
  assign sts.full      = (32'(rows_open) == MAX_DEPTH);
  assign sts.empty     = (rows_open == '0) || (ncol == '0);
  assign sts.clr_last  = (clr_col == CW'(MAX_COLORS - 1));
  assign d_last        = (32'(scan_d) + 1 == 32'(rows_open));
  assign c_last        = (32'(scan_c) + 1 == 32'(ncol));
  assign sts.scan_last = c_last && d_last;
  assign sts.out_free  = !m_tvalid || m_tready;

  assign bad_req = (in_req == REQ_OPEN && sts.full) ||
                   ((in_req == REQ_INC || in_req == REQ_DEC) && !sts.range_ok);

  // saturating update of the counter just read
  always_comb begin
    if (req_q == REQ_INC) begin
      upd_val = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
    end else begin
      upd_val = (ram_rdata == '0) ? ram_rdata : ram_rdata - COUNT_BITS'(1);
    end
  end

  assign ram_raddr = cmd.rd_upd ? in_addr : {scan_d, scan_c};
  assign ram_we    = cmd.wr_upd || cmd.clr_wr;
  assign ram_waddr = cmd.clr_wr ? {DW'(rows_open), clr_col} : addr_q;
  assign ram_wdata = cmd.clr_wr ? '0 : upd_val;

  cdha_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      color_limit <= COLOR_LIMIT_RESET;
      rows_open   <= '0;
      pipe_v      <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        color_limit <= cfg_wdata;
      end
      if (cmd.open_inc) begin
        rows_open <= rows_open + RW'(1);
      end
      pipe_v <= cmd.scan_rd;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request, sweep and result registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q      <= in_req;
      addr_q     <= in_addr;
      clr_col    <= '0;
      scan_c     <= '0;
      scan_d     <= '0;
      res_best   <= '0;
      res_c      <= '0;
      res_d      <= '0;
      res_found  <= 1'b0;
      res_status <= bad_req ? STAT_RANGE : STAT_OK;
    end
    if (cmd.clr_wr) begin
      clr_col <= clr_col + CW'(1);
    end
    if (cmd.wr_upd && req_q == REQ_DEC && ram_rdata == '0) begin
      res_status <= STAT_UNDERFLOW;
    end
    // depths inner, colors outer
    if (cmd.scan_rd) begin
      pipe_c <= scan_c;
      pipe_d <= scan_d;
      if (d_last) begin
        scan_d <= '0;
        scan_c <= scan_c + CW'(1);
      end else begin
        scan_d <= scan_d + DW'(1);
      end
    end
    // strict compare keeps the first maximum
    if (pipe_v && ram_rdata > res_best) begin
      res_best  <= ram_rdata;
      res_c     <= pipe_c;
      res_d     <= pipe_d;
      res_found <= 1'b1;
    end
    if (cmd.out_load) begin
      m_tdata <= {5'b0, res_status, res_found, 16'(res_best), 4'(res_d), 4'(res_c)};
    end
  end

endmodule

/* src/color_depth_histogram_argmax.sv */
// ----------------------------------------------------------------------------
// color_depth_histogram_argmax
// Table of 16-bit counters by depth row and color with an argmax scan. Each
// request word gives exactly one result word. Rows are opened one at a time
// and cleared as they open, one write per column into the counter RAM.
// Increment and decrement are a read-modify-write on the counter RAM, which
// is single-port-per-direction. A query reads every open entry once, colors
// outer and depths inner. No clearing pass runs after reset. A result word
// can wait in the output register while the next request is taken. The color
// limit is written through cfg_we / cfg_wdata; the user must write it only
// while no request is in flight, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module color_depth_histogram_argmax #(
  parameter int MAX_COLORS = 16,
  parameter int MAX_DEPTH  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cdha_pkg::CFG_W-1:0]     cfg_wdata,   // color limit
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [cdha_pkg::S_TDATA_W-1:0] s_tdata,     // req_type[1:0], color[5:2], depth[9:6]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [cdha_pkg::M_TDATA_W-1:0] m_tdata      // max color[3:0], best_depth[7:4],
                                                      // best_count[23:8], found[24],
                                                      // status[26:25]
);
  import cdha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cdha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cdha_dp #(
    .MAX_COLORS (MAX_COLORS),
    .MAX_DEPTH  (MAX_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in flight");

  // write-back follows its own read
  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_upd |-> $past(cmd.rd_upd))
    else $error("counter write-back without a preceding read");

  // a found maximum only comes from a query, which reports ok
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[24] |-> m_tdata[26:25] == STAT_OK)
    else $error("found set on a word with error status");

endmodule
